@@ sv/tbsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsg_pkg: shared types and constants
// Opcodes, direction codes, register indexes and result records for the
// trackball swipe gesture classifier.
// ----------------------------------------------------------------------------
package tbsg_pkg;

  localparam int ACC_W     = 18;
  localparam int TAP_W     = 16;
  localparam int THR_W     = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_RESET = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD      = 3'd0,
    REG_OUTLIER_LIMIT  = 3'd1,
    REG_STEP_SIZE      = 3'd2,
    REG_ACCUM_LIMIT    = 3'd3,
    REG_TAP_LENGTH     = 3'd4,
    REG_COOLDOWN       = 3'd5,
    REG_KEEP_REMAINDER = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic is_press;
    dir_t direction;
    logic last;
  } res_t;

  // up to two results produced by one item, first goes out first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

@@ sv/tbsg_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsg_in_if: input item channel
// Valid/ready channel carrying one movement, tick or reset item per beat.
// ----------------------------------------------------------------------------
interface tbsg_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic                          axis;
  logic signed [SAMPLE_BITS-1:0] move_value;
  logic                          frame_end;
  logic                          layer_active;

  modport source (
    output valid, opcode, axis, move_value, frame_end, layer_active,
    input  ready
  );
  modport sink (
    input  valid, opcode, axis, move_value, frame_end, layer_active,
    output ready
  );
endinterface

@@ sv/tbsg_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsg_out_if: result channel
// Valid/ready channel carrying one press or release event per beat.
// ----------------------------------------------------------------------------
interface tbsg_out_if;
  logic       valid;
  logic       ready;
  logic       is_press;
  logic [1:0] direction;
  logic       last;

  modport source (
    output valid, is_press, direction, last,
    input  ready
  );
  modport sink (
    input  valid, is_press, direction, last,
    output ready
  );
endinterface

@@ sv/tbsg_res_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsg_res_fifo: result queue
// Four-entry queue taking zero, one or two results per cycle and
// delivering one beat per cycle on the result side while out_ready is high.
// ----------------------------------------------------------------------------
module tbsg_res_fifo
  import tbsg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room2,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr1;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign wr_ptr1   = wr_ptr_r + PTR_W'(1);
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign room2     = (count_r <= CNT_W'(DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ sv/trackball_swipe_gesture_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trackball_swipe_gesture_classifier_unit: swipe gesture classifier
// Scores movement frames into signed axis accumulators, fires right, left, up
// or down presses with cooldown; releases on tap timeout, new press or reset.
// ----------------------------------------------------------------------------
// Order: an item waits in the input register until the result queue has room
//   for two results, then is scored into the four-entry result queue.
// Throughput: one item per cycle while that queue has room; the result side
//   gives one beat per cycle while ready, pacing items with two results.
// Reset: synchronous rst_n loads register defaults and clears all gesture
//   state at once; items are taken from the first cycle after reset.
module trackball_swipe_gesture_classifier_unit
  import tbsg_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tbsg_in_if.sink              in_ch,
  tbsg_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int S     = SAMPLE_BITS;
  localparam int OW    = (S > THR_W) ? S : THR_W;
  localparam int SUM_W = ((S + 3 > ACC_W) ? S + 3 : ACC_W) + 1;
  localparam int CW    = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  // configuration registers
  logic [THR_W-1:0] thr_r, outl_lim_r;
  logic [CFG_W-1:0] step_r, alim_r, tap_len_r, cool_r;
  logic             keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_W'(2);
      outl_lim_r <= THR_W'(200);
      step_r     <= CFG_W'(80);
      alim_r     <= CFG_W'(160);
      tap_len_r  <= CFG_W'(35);
      cool_r     <= CFG_W'(120);
      keep_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:      thr_r      <= cfg_wdata[THR_W-1:0];
        REG_OUTLIER_LIMIT:  outl_lim_r <= cfg_wdata[THR_W-1:0];
        REG_STEP_SIZE:      step_r     <= cfg_wdata;
        REG_ACCUM_LIMIT:    alim_r     <= cfg_wdata;
        REG_TAP_LENGTH:     tap_len_r  <= cfg_wdata;
        REG_COOLDOWN:       cool_r     <= cfg_wdata;
        REG_KEEP_REMAINDER: keep_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register, sample magnitude and outlier check done on capture
  logic         in_v_r, in_v_nxt;
  op_t          op_r;
  logic         axis_r, neg_r, fend_r, layer_r, outl_r;
  logic [S-1:0] mag_r;
  logic [S-1:0] raw, raw_mag;
  logic         take, advance, room2;

  assign raw     = in_ch.move_value;
  assign raw_mag = raw[S-1] ? (~raw + S'(1)) : raw;

  assign advance     = in_v_r && room2;
  assign in_ch.ready = rst_n && (!in_v_r || advance);
  assign take        = in_ch.valid && in_ch.ready;
  assign in_v_nxt    = take ? 1'b1 : (advance ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= op_t'(in_ch.opcode);
      axis_r  <= in_ch.axis;
      neg_r   <= raw[S-1];
      mag_r   <= raw_mag;
      fend_r  <= in_ch.frame_end;
      layer_r <= in_ch.layer_active;
      outl_r  <= OW'(raw_mag) > OW'(outl_lim_r);
    end
  end

  // gesture state; frame reports kept as magnitude and sign
  logic [S-1:0]         fxm_r, fxm_nxt, fym_r, fym_nxt;
  logic                 fxn_r, fxn_nxt, fyn_r, fyn_nxt;
  logic signed [ACC_W-1:0] accx_r, accx_nxt, accy_r, accy_nxt;
  logic                 held_v_r, held_v_nxt, pb_r, pb_nxt;
  dir_t                 held_dir_r, held_dir_nxt;
  logic [TAP_W-1:0]     tap_r, tap_nxt;
  logic [TIME_BITS-1:0] since_r, since_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      fxm_r      <= '0;
      fym_r      <= '0;
      fxn_r      <= 1'b0;
      fyn_r      <= 1'b0;
      accx_r     <= '0;
      accy_r     <= '0;
      held_v_r   <= 1'b0;
      held_dir_r <= DIR_RIGHT;
      pb_r       <= 1'b0;
      tap_r      <= '0;
      since_r    <= '0;
    end else begin
      in_v_r     <= in_v_nxt;
      fxm_r      <= fxm_nxt;
      fym_r      <= fym_nxt;
      fxn_r      <= fxn_nxt;
      fyn_r      <= fyn_nxt;
      accx_r     <= accx_nxt;
      accy_r     <= accy_nxt;
      held_v_r   <= held_v_nxt;
      held_dir_r <= held_dir_nxt;
      pb_r       <= pb_nxt;
      tap_r      <= tap_nxt;
      since_r    <= since_nxt;
    end
  end

  // frame scoring
  logic [S-1:0]       fx_m, fy_m, hi, lo;
  logic               fx_n, fy_n, xdom, moving, dom_neg;
  logic [S+1:0]       lo3;
  logic [S:0]         est;
  logic signed [SUM_W-1:0] acc_ext, est_ext, sum, lim_ext, clamped;
  logic signed [ACC_W-1:0] acc_cl, accx_s, accy_s;

  assign fx_m    = axis_r ? fxm_r : mag_r;
  assign fx_n    = axis_r ? fxn_r : neg_r;
  assign fy_m    = axis_r ? mag_r : fym_r;
  assign fy_n    = axis_r ? neg_r : fyn_r;
  assign moving  = !((OW'(fx_m) < OW'(thr_r)) && (OW'(fy_m) < OW'(thr_r)));
  assign xdom    = fx_m >= fy_m;
  assign hi      = xdom ? fx_m : fy_m;
  assign lo      = xdom ? fy_m : fx_m;
  assign dom_neg = xdom ? fx_n : fy_n;
  assign lo3     = {2'b00, lo} + {1'b0, lo, 1'b0};
  assign est     = {1'b0, hi} + (S + 1)'(lo3 >> 3);

  assign acc_ext = xdom ? SUM_W'(accx_r) : SUM_W'(accy_r);
  assign est_ext = signed'({{(SUM_W - S - 1){1'b0}}, est});
  assign lim_ext = signed'({{(SUM_W - CFG_W){1'b0}}, alim_r});
  assign sum     = dom_neg ? (acc_ext - est_ext) : (acc_ext + est_ext);
  assign clamped = (sum > lim_ext) ? lim_ext : ((sum < -lim_ext) ? -lim_ext : sum);
  assign acc_cl  = clamped[ACC_W-1:0];
  assign accx_s  = (moving && xdom) ? acc_cl : accx_r;
  assign accy_s  = (moving && !xdom) ? acc_cl : accy_r;

  // direction choice
  logic [ACC_W-1:0]        aax, aay, step_ext;
  logic [CFG_W-1:0]        step_eff;
  logic                    found, xdom2, pos, blocked;
  dir_t                    fire_dir;
  logic signed [ACC_W-1:0] accx_c, accy_c, step_s;

  assign aax      = accx_s[ACC_W-1] ? ACC_W'(-accx_s) : ACC_W'(accx_s);
  assign aay      = accy_s[ACC_W-1] ? ACC_W'(-accy_s) : ACC_W'(accy_s);
  assign step_eff = (step_r == '0) ? CFG_W'(1) : step_r;
  assign step_ext = ACC_W'(step_eff);
  assign step_s   = signed'(step_ext);
  assign found    = !((aax < step_ext) && (aay < step_ext));
  assign xdom2    = aax >= aay;
  assign pos      = xdom2 ? !accx_s[ACC_W-1] : !accy_s[ACC_W-1];
  assign blocked  = (cool_r != '0) && pb_r && (CW'(since_r) < CW'(cool_r));

  always_comb begin
    accx_c   = accx_s;
    accy_c   = accy_s;
    fire_dir = DIR_RIGHT;
    if (found) begin
      if (xdom2) begin
        accy_c   = '0;
        fire_dir = pos ? DIR_RIGHT : DIR_LEFT;
        if (keep_r) begin
          accx_c = pos ? (accx_s - step_s) : (accx_s + step_s);
        end
      end else begin
        accx_c   = '0;
        fire_dir = pos ? DIR_UP : DIR_DOWN;
        if (keep_r) begin
          accy_c = pos ? (accy_s - step_s) : (accy_s + step_s);
        end
      end
    end
  end

  // state update and results
  push_t        push;
  logic         do_rel, do_press;
  logic [TAP_W-1:0] tap_dec;
  res_t         rel_res, press_res;

  assign tap_dec   = (tap_r != '0) ? (tap_r - TAP_W'(1)) : tap_r;
  assign rel_res   = '{is_press: 1'b0, direction: held_dir_r, last: !do_press};
  assign press_res = '{is_press: 1'b1, direction: fire_dir, last: 1'b1};

  always_comb begin
    fxm_nxt      = fxm_r;
    fym_nxt      = fym_r;
    fxn_nxt      = fxn_r;
    fyn_nxt      = fyn_r;
    accx_nxt     = accx_r;
    accy_nxt     = accy_r;
    held_v_nxt   = held_v_r;
    held_dir_nxt = held_dir_r;
    pb_nxt       = pb_r;
    tap_nxt      = tap_r;
    since_nxt    = since_r;
    do_rel       = 1'b0;
    do_press     = 1'b0;
    if (advance) begin
      case (op_r)
        OP_MOVE: begin
          if (layer_r) begin
            if (outl_r) begin
              fxm_nxt = '0;
              fym_nxt = '0;
              fxn_nxt = 1'b0;
              fyn_nxt = 1'b0;
            end else if (!fend_r) begin
              fxm_nxt = fx_m;
              fym_nxt = fy_m;
              fxn_nxt = fx_n;
              fyn_nxt = fy_n;
            end else begin
              fxm_nxt  = '0;
              fym_nxt  = '0;
              fxn_nxt  = 1'b0;
              fyn_nxt  = 1'b0;
              accx_nxt = accx_c;
              accy_nxt = accy_c;
              if (found && !blocked) begin
                do_press     = 1'b1;
                do_rel       = held_v_r;
                held_v_nxt   = 1'b1;
                held_dir_nxt = fire_dir;
                pb_nxt       = 1'b1;
                since_nxt    = '0;
                tap_nxt      = tap_len_r;
                if (!keep_r) begin
                  accx_nxt = '0;
                  accy_nxt = '0;
                end
              end
            end
          end
        end
        OP_TICK: begin
          if (since_r != '1) begin
            since_nxt = since_r + TIME_BITS'(1);
          end
          if (held_v_r) begin
            tap_nxt = tap_dec;
            if (tap_dec == '0) begin
              do_rel     = 1'b1;
              held_v_nxt = 1'b0;
            end
          end
        end
        OP_RESET: begin
          do_rel     = held_v_r;
          held_v_nxt = 1'b0;
          fxm_nxt    = '0;
          fym_nxt    = '0;
          fxn_nxt    = 1'b0;
          fyn_nxt    = 1'b0;
          accx_nxt   = '0;
          accy_nxt   = '0;
          pb_nxt     = 1'b0;
          since_nxt  = '0;
          tap_nxt    = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    push.cnt    = 2'(do_rel) + 2'(do_press);
    push.first  = do_rel ? rel_res : press_res;
    push.second = press_res;
  end

  res_t out_res;

  tbsg_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.is_press  = out_res.is_press;
  assign out_ch.direction = out_res.direction;
  assign out_ch.last      = out_res.last;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !room2) |-> !in_ch.ready)
    else $error("input taken while result queue is full");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (!push.first.is_press && !push.first.last &&
                            push.second.is_press && push.second.last))
    else $error("two-result beat is not release then press");

  a_press_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && do_press) |=> (held_v_r && pb_r && since_r == '0))
    else $error("press did not update held state");

  a_reset_gesture: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op_r == OP_RESET) |=> (!held_v_r && !pb_r && accx_r == '0 &&
                                       accy_r == '0))
    else $error("reset gesture left state behind");
`endif

endmodule

@@ tb/tb_trackball_swipe_gesture_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trackball_swipe_gesture_classifier_unit: self-checking bench
// Walks a short table of directed items, then several register settings
// with random frames, tick bursts, resets and noise. Every beat taken on the
// input runs through a local gesture predictor; result beats are compared
// in order against the predicted press/release events, or a row's known events.
// ----------------------------------------------------------------------------
module tb_trackball_swipe_gesture_classifier_unit;
  import tbsg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE    = 8;
  localparam int HOLD_LEN  = 200;
  localparam int CYCLE_CAP = 300000;

  typedef struct {
    logic [1:0]         op;
    logic               axis;
    logic signed [15:0] value;
    logic               frame_end;
    logic               layer;
    int                 known_n;   // -1: take the predictor's events
    res_t               known_ev;
  } stim_t;

  typedef struct {
    logic [THR_W-1:0] threshold;
    logic [THR_W-1:0] outlier;
    logic [15:0]      stp;
    logic [15:0]      alim;
    logic [15:0]      tap;
    logic [15:0]      cool;
    logic             keep;
  } knob_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  tbsg_in_if #(.SAMPLE_BITS(16)) in_bus ();
  tbsg_out_if                    out_bus ();

  trackball_swipe_gesture_classifier_unit #(
    .SAMPLE_BITS(16),
    .TIME_BITS  (16)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gesture predictor state
  knob_t                   g_cfg;
  logic signed [15:0]      g_frame_x, g_frame_y;
  logic signed [ACC_W-1:0] g_acc_x, g_acc_y;
  logic                    g_held, g_pressed;
  dir_t                    g_held_dir;
  logic [TAP_W-1:0]        g_tap_cnt, g_since;
  res_t                    ev_buf[2];
  int                      ev_n;

  stim_t stim_q[$];
  res_t  event_q[$];
  stim_t cur_item;
  int    items_sent, items_taken, err_count, cycles;
  int    src_wait, sink_wait, pred_n;
  bit    src_calm, sink_calm, hold_go;
  logic  sink_hold;

  function automatic void emit_event(logic press, dir_t d);
    ev_buf[ev_n] = '{is_press: press, direction: d, last: 1'b0};
    ev_n++;
  endfunction

  function automatic void drop_held();
    if (g_held) begin
      g_held = 1'b0;
      emit_event(1'b0, g_held_dir);
    end
  endfunction

  function automatic int gesture_step(input stim_t it);
    int   v, x, y, ax, ay, hi, lo, mg, acc, lim, stp, acx, acy;
    bit   fire;
    dir_t d;
    ev_n = 0;
    d    = DIR_RIGHT;
    case (it.op)
      OP_MOVE: begin
        if (it.layer) begin
          v = int'(it.value);
          if ((v < 0 ? -v : v) > int'(g_cfg.outlier)) begin
            g_frame_x = '0;
            g_frame_y = '0;
          end else begin
            if (it.axis) g_frame_y = v[15:0];
            else g_frame_x = v[15:0];
            if (it.frame_end) begin
              x = int'(g_frame_x);
              y = int'(g_frame_y);
              ax = x < 0 ? -x : x;
              ay = y < 0 ? -y : y;
              g_frame_x = '0;
              g_frame_y = '0;
              lim = int'(g_cfg.alim);
              if (ax >= int'(g_cfg.threshold) || ay >= int'(g_cfg.threshold)) begin
                hi = ax >= ay ? ax : ay;
                lo = ax >= ay ? ay : ax;
                mg = hi + ((lo * 3) >> 3);
                if (ax >= ay) begin
                  acc = int'(g_acc_x);
                  acc = acc + (x < 0 ? -mg : mg);
                  if (acc > lim) acc = lim;
                  if (acc < -lim) acc = -lim;
                  g_acc_x = acc[ACC_W-1:0];
                end else begin
                  acc = int'(g_acc_y);
                  acc = acc + (y < 0 ? -mg : mg);
                  if (acc > lim) acc = lim;
                  if (acc < -lim) acc = -lim;
                  g_acc_y = acc[ACC_W-1:0];
                end
              end
              stp = (g_cfg.stp == 0) ? 1 : int'(g_cfg.stp);
              acx = int'(g_acc_x);
              acy = int'(g_acc_y);
              ax = acx < 0 ? -acx : acx;
              ay = acy < 0 ? -acy : acy;
              if (ax >= stp || ay >= stp) begin
                fire = 1'b1;
                if (ax >= ay) begin
                  g_acc_y = '0;
                  if (acx > 0) begin
                    d = DIR_RIGHT;
                    if (g_cfg.keep) acx = acx - stp;
                  end else begin
                    d = DIR_LEFT;
                    if (g_cfg.keep) acx = acx + stp;
                  end
                  g_acc_x = acx[ACC_W-1:0];
                end else begin
                  g_acc_x = '0;
                  if (acy > 0) begin
                    d = DIR_UP;
                    if (g_cfg.keep) acy = acy - stp;
                  end else begin
                    d = DIR_DOWN;
                    if (g_cfg.keep) acy = acy + stp;
                  end
                  g_acc_y = acy[ACC_W-1:0];
                end
                if (g_cfg.cool != 0 && g_pressed && g_since < g_cfg.cool) fire = 1'b0;
                if (fire) begin
                  drop_held();
                  emit_event(1'b1, d);
                  g_held     = 1'b1;
                  g_held_dir = d;
                  g_pressed  = 1'b1;
                  g_since    = '0;
                  g_tap_cnt  = g_cfg.tap;
                  if (!g_cfg.keep) begin
                    g_acc_x = '0;
                    g_acc_y = '0;
                  end
                end
              end
            end
          end
        end
      end
      OP_TICK: begin
        if (g_since != '1) g_since++;
        if (g_held) begin
          if (g_tap_cnt > 0) g_tap_cnt--;
          if (g_tap_cnt == 0) drop_held();
        end
      end
      OP_RESET: begin
        drop_held();
        g_frame_x = '0;
        g_frame_y = '0;
        g_acc_x   = '0;
        g_acc_y   = '0;
        g_pressed = 1'b0;
        g_since   = '0;
        g_tap_cnt = '0;
      end
      default: ;
    endcase
    if (ev_n > 0) ev_buf[ev_n-1].last = 1'b1;
    return ev_n;
  endfunction

  function automatic stim_t mk(logic [1:0] op, logic ax, logic signed [15:0] val,
                               logic fe, logic la, int kn, logic press, dir_t d);
    stim_t s;
    s.op        = op;
    s.axis      = ax;
    s.value     = val;
    s.frame_end = fe;
    s.layer     = la;
    s.known_n   = kn;
    s.known_ev  = '{is_press: press, direction: d, last: 1'b1};
    return s;
  endfunction

  function automatic logic signed [15:0] rand_move();
    int outl, span, mg;
    outl = int'(g_cfg.outlier);
    span = int'(g_cfg.threshold) + 2 * ((g_cfg.stp == 0) ? 1 : int'(g_cfg.stp)) + 4;
    if (span > outl) span = outl;
    case ($urandom_range(0, 9))
      0:          mg = outl;
      1, 2, 3, 4: mg = $urandom_range(0, outl);
      default:    mg = $urandom_range(0, span);
    endcase
    if ($urandom_range(0, 1)) mg = -mg;
    return mg[15:0];
  endfunction

  task automatic offer(input stim_t s);
    stim_q.push_back(s);
    items_sent++;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    err_count++;
  endtask

  // input side: draw a gap per item, keep valid up until the beat is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        pred_n = gesture_step(cur_item);
        if (cur_item.known_n >= 0) begin
          if (cur_item.known_n == 1) event_q.push_back(cur_item.known_ev);
        end else begin
          for (int i = 0; i < pred_n; i++) event_q.push_back(ev_buf[i]);
        end
        items_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (src_wait > 0) begin
          src_wait--;
          in_bus.valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_item = stim_q.pop_front();
          in_bus.opcode       <= cur_item.op;
          in_bus.axis         <= cur_item.axis;
          in_bus.move_value   <= cur_item.value;
          in_bus.frame_end    <= cur_item.frame_end;
          in_bus.layer_active <= cur_item.layer;
          in_bus.valid        <= 1'b1;
          src_wait = src_calm ? 0 : $urandom_range(0, 4);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end else begin
      in_bus.valid        <= 1'b0;
      in_bus.opcode       <= OP_TICK;
      in_bus.axis         <= 1'b0;
      in_bus.move_value   <= '0;
      in_bus.frame_end    <= 1'b0;
      in_bus.layer_active <= 1'b0;
      g_frame_x  = '0;
      g_frame_y  = '0;
      g_acc_x    = '0;
      g_acc_y    = '0;
      g_held     = 1'b0;
      g_pressed  = 1'b0;
      g_held_dir = DIR_RIGHT;
      g_tap_cnt  = '0;
      g_since    = '0;
    end
  end

  // result side: check each beat, then stall for a drawn number of cycles
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (event_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat press=%0d dir=%0d last=%0d",
                                    out_bus.is_press, out_bus.direction, out_bus.last));
        end else begin
          want = event_q.pop_front();
          if (out_bus.is_press !== want.is_press || out_bus.direction !== want.direction ||
              out_bus.last !== want.last)
            report_mismatch($sformatf("got press=%0d dir=%0d last=%0d, want %0d/%0d/%0d",
                                      out_bus.is_press, out_bus.direction, out_bus.last,
                                      want.is_press, want.direction, want.last));
        end
        sink_wait = sink_calm ? 0 : $urandom_range(0, 4);
      end
      if (sink_hold) begin
        out_bus.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end else begin
      out_bus.ready <= 1'b0;
    end
  end

  // long receiver hold-off so the result queue fills and input backs up
  initial begin
    sink_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("trackball_swipe_gesture_classifier_unit test failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (!(items_taken == items_sent && event_q.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_knobs(input knob_t k);
    logic [CFG_W-1:0] w;
    for (int i = 0; i <= int'(REG_KEEP_REMAINDER); i++) begin
      case (cfg_reg_t'(i))
        REG_THRESHOLD:     w = CFG_W'(k.threshold);
        REG_OUTLIER_LIMIT: w = CFG_W'(k.outlier);
        REG_STEP_SIZE:     w = k.stp;
        REG_ACCUM_LIMIT:   w = k.alim;
        REG_TAP_LENGTH:    w = k.tap;
        REG_COOLDOWN:      w = k.cool;
        default:           w = CFG_W'(k.keep);
      endcase
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= w;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    g_cfg = k;
  endtask

  task automatic queue_random(input int budget, input int burst_cap);
    int   taken, r, n;
    logic ax;
    taken = 0;
    while (taken < budget) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        ax = 1'($urandom_range(0, 1));
        offer(mk(OP_MOVE, ax, rand_move(), 1'b0, 1'b1, -1, 1'b0, DIR_RIGHT));
        offer(mk(OP_MOVE, !ax, rand_move(), 1'b1, 1'b1, -1, 1'b0, DIR_RIGHT));
        taken += 2;
      end else if (r < 63) begin
        n = $urandom_range(1, burst_cap);
        repeat (n) offer(mk(OP_TICK, 1'($urandom_range(0, 1)), 16'($urandom()),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            -1, 1'b0, DIR_RIGHT));
        taken += n;
      end else if (r < 71) begin
        offer(mk(OP_MOVE, 1'($urandom_range(0, 1)), rand_move(), 1'b1, 1'b1, -1, 1'b0,
                 DIR_RIGHT));
        taken++;
      end else if (r < 76) begin
        offer(mk(OP_RESET, 1'($urandom_range(0, 1)), 16'($urandom()),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), -1, 1'b0, DIR_RIGHT));
        taken++;
      end else if (r < 83) begin
        offer(mk(OP_MOVE, 1'($urandom_range(0, 1)), 16'($urandom()),
                 1'($urandom_range(0, 1)), 1'b1, -1, 1'b0, DIR_RIGHT));
        taken++;
      end else if (r < 90) begin
        // layer off: ignored by the block, not counted
        offer(mk(OP_MOVE, 1'($urandom_range(0, 1)), 16'($urandom()),
                 1'($urandom_range(0, 1)), 1'b0, -1, 1'b0, DIR_RIGHT));
      end else if (r < 94) begin
        offer(mk(OP_UNUSED, 1'($urandom_range(0, 1)), 16'($urandom()),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), -1, 1'b0, DIR_RIGHT));
      end else begin
        offer(mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 16'($urandom()),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), -1, 1'b0, DIR_RIGHT));
        taken++;
      end
    end
  endtask

  task automatic run_phase(input knob_t k, input int budget, input bit s_calm,
                           input bit r_calm, input bit hold);
    int cap;
    wait_idle();
    load_knobs(k);
    src_calm  = s_calm;
    sink_calm = r_calm;
    cap = (k.tap > k.cool ? int'(k.tap) : int'(k.cool)) + 2;
    if (cap > 40) cap = 40;
    if (hold) hold_go = 1'b1;
    queue_random(budget, cap);
  endtask

  initial begin
    stim_t tab[$];
    knob_t k;
    rst_n   <= 1'b0;
    cfg_we  <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    items_sent = 0;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    hold_go = 1'b0;
    g_cfg = '{threshold: 2, outlier: 200, stp: 80, alim: 160, tap: 35, cool: 120, keep: 0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows under the register defaults
    tab.push_back(mk(OP_TICK,   0, 16'sd0,     0, 1,  0, 0, DIR_RIGHT));
    tab.push_back(mk(OP_UNUSED, 1, -16'sd1,    1, 1,  0, 0, DIR_RIGHT));
    tab.push_back(mk(OP_RESET,  0, 16'sd0,     0, 1,  0, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   0, 16'sh7FFF,  1, 0,  0, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   0, 16'sh8000,  1, 1,  0, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   1, 16'sd201,   1, 1,  0, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   0, 16'sd200,   0, 1,  0, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   1, 16'sd0,     1, 1,  1, 1, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   0, -16'sd100,  1, 1, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_TICK,   0, 16'sd0,     0, 1, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_RESET,  0, 16'sd0,     0, 1,  1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   1, 16'sd150,   0, 1, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   0, 16'sd50,    1, 1, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   1, -16'sd1,    1, 1, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_RESET,  1, 16'sd0,     1, 0, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   1, -16'sd120,  1, 1, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_RESET,  0, 16'sd0,     0, 1,  1, 0, DIR_DOWN));
    tab.push_back(mk(OP_MOVE,   0, 16'sd1,     1, 1, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   0, 16'sd2,     1, 1, -1, 0, DIR_RIGHT));
    tab.push_back(mk(OP_MOVE,   1, -16'sd90,   1, 1, -1, 0, DIR_RIGHT));
    foreach (tab[i]) offer(tab[i]);

    k = '{threshold: 2, outlier: 200, stp: 80, alim: 160, tap: 35, cool: 120, keep: 0};
    run_phase(k, 60, 0, 0, 0);
    k = '{threshold: 0, outlier: 32767, stp: 1, alim: 65535, tap: 0, cool: 0, keep: 1};
    run_phase(k, 70, 1, 1, 0);
    k = '{threshold: 32767, outlier: 32767, stp: 65535, alim: 65535, tap: 65535,
          cool: 65535, keep: 0};
    run_phase(k, 50, 0, 0, 0);
    k = '{threshold: 0, outlier: 0, stp: 0, alim: 0, tap: 0, cool: 0, keep: 0};
    run_phase(k, 30, 0, 1, 0);
    k = '{threshold: 3, outlier: 100, stp: 20, alim: 60, tap: 2, cool: 4, keep: 1};
    run_phase(k, 90, 1, 0, 0);
    k = '{threshold: 1, outlier: 500, stp: 40, alim: 100, tap: 5, cool: 0, keep: 0};
    run_phase(k, 80, 1, 0, 1);
    k = '{threshold: 5, outlier: 1000, stp: 200, alim: 400, tap: 1, cool: 10, keep: 1};
    run_phase(k, 70, 0, 0, 0);
    k.threshold = THR_W'($urandom_range(0, 20));
    k.outlier   = THR_W'($urandom_range(20, 2000));
    k.stp       = 16'($urandom_range(0, 300));
    k.alim      = 16'($urandom_range(0, 600));
    k.tap       = 16'($urandom_range(0, 6));
    k.cool      = 16'($urandom_range(0, 12));
    k.keep      = 1'($urandom_range(0, 1));
    run_phase(k, 50, 0, 0, 0);

    wait_idle();
    if (err_count == 0) begin
      $display("trackball_swipe_gesture_classifier_unit test passed");
    end else begin
      $display("trackball_swipe_gesture_classifier_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tbsg_pkg.sv
sv/tbsg_in_if.sv
sv/tbsg_out_if.sv
sv/tbsg_res_fifo.sv
sv/trackball_swipe_gesture_classifier_unit.sv
tb/tb_trackball_swipe_gesture_classifier_unit.sv
